// ----- rtl/core/esc_pkg.sv -----
// shared types, register indexes, constants and helpers for the compensation block
`default_nettype none
package esc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_CAL_TEMP  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_LOW = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_LAST = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CAL_HUM   = 3'd4;

  localparam logic [23:0] SKIP24 = 24'h800000;
  localparam logic [15:0] SKIP16 = 16'h8000;
  localparam logic [31:0] HUM_MAX = 32'd419430400;

  typedef struct packed {
    logic [23:0] raw_temp;
    logic [23:0] raw_press;
    logic [15:0] raw_hum;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic               temp_ok;
    logic [31:0]        press_q24_8;
    logic               press_ok;
    logic [16:0]        hum_q22_10;
    logic               hum_ok;
  } out_item_t;

  typedef enum logic [5:0] {
    S_IDLE, S_WAIT,
    S_TA, S_TB, S_TC, S_TD, S_TE, S_TF,
    S_PA, S_PB, S_PC, S_PD, S_PE, S_PF, S_PG, S_PH, S_PI,
    S_PJ, S_PK, S_PL, S_PM, S_PN, S_PO, S_PP, S_PQ,
    S_HA, S_HB, S_HC, S_HD, S_HE, S_HF, S_HG, S_HH, S_HI,
    S_HJ, S_HK, S_HL, S_HM, S_HN,
    S_FIN
  } seq_state_t;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    sx32 = {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/env_sensor_compensation_unit.sv -----
// top level: calibration registers, sequencer and result register
// Use: one item on the input channel carries raw temperature, pressure and
// humidity words; one item on the output channel returns the compensated
// temperature, pressure and humidity with a valid flag for each.
// Both channels handshake with valid and stall; an item moves on a rising
// edge with valid high and stall low. Calibration is written through cfg_we /
// cfg_index / cfg_data; the user must write it only while no item is in flight,
// as the block does not enforce this. The block works on one item at a time:
// in_stall is high from acceptance until the result is loaded into the output
// register. A new item can be taken while that result still waits on out_stall.
// Time per item is data dependent: with all three readings skipped the
// sequencer goes straight from idle to its final state; otherwise it is set by
// the shared bit-serial multiplier (one multiplier bit per cycle, ending when
// the remaining bits are zero, up to 21 products per item) and the 64-step
// serial divider used once for pressure. Skipped readings drop their section entirely.
// Synchronous reset clears the calibration words, the fine temperature and
// all control state; the output register stays empty until the first result.
// While the receiver stalls, the finished result is held and the sequencer
// waits before overwriting it.
`default_nettype none
module env_sensor_compensation_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire esc_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output esc_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [esc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [63:0]                    cfg_data
);

  logic [47:0] cal_temp;
  logic [63:0] cal_plo;
  logic [63:0] cal_phi;
  logic [15:0] cal_plast;
  logic [63:0] cal_hum;
  logic [31:0] fine_temp;

  esc_pkg::seq_state_t state, state_next, ret, ret_next;

  logic [23:0] raw_t;
  logic [23:0] raw_p;
  logic [15:0] raw_h;
  logic        tok, pok, hok;
  logic [63:0] ra, rb, rc, rd, re;
  logic [31:0] temp_r;
  logic [31:0] press_r;
  logic [16:0] hum_r;

  logic        mul_start, div_start, mul_done, div_done;
  logic [63:0] mul_a, mul_b, mul_p, div_q;
  logic [31:0] p32;
  logic        out_free;

  logic [63:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  logic [19:0] adc_t, adc_p;
  logic [31:0] hx, hv;
  logic [63:0] ts;

  esc_pkg::seq_state_t after_t, after_p;

  assign t1 = {48'd0, cal_temp[15:0]};
  assign t2 = esc_pkg::sx16(cal_temp[31:16]);
  assign t3 = esc_pkg::sx16(cal_temp[47:32]);
  assign p1 = {48'd0, cal_plo[15:0]};
  assign p2 = esc_pkg::sx16(cal_plo[31:16]);
  assign p3 = esc_pkg::sx16(cal_plo[47:32]);
  assign p4 = esc_pkg::sx16(cal_plo[63:48]);
  assign p5 = esc_pkg::sx16(cal_phi[15:0]);
  assign p6 = esc_pkg::sx16(cal_phi[31:16]);
  assign p7 = esc_pkg::sx16(cal_phi[47:32]);
  assign p8 = esc_pkg::sx16(cal_phi[63:48]);
  assign p9 = esc_pkg::sx16(cal_plast);
  assign h1 = {24'd0, cal_hum[7:0]};
  assign h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
  assign h3 = {24'd0, cal_hum[31:24]};
  assign h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
  assign h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
  assign h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};

  assign adc_t = raw_t[23:4];
  assign adc_p = raw_p[23:4];
  assign p32   = mul_p[31:0];
  assign ts    = esc_pkg::sx32(fine_temp);

  assign hx = 32'($signed({2'b00, raw_h, 14'd0} - {h4[11:0], 20'd0} - p32 + 32'd16384)
              >>> 15);
  assign hv = rd[31:0] - 32'($signed(p32) >>> 4);

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != esc_pkg::S_IDLE);

  assign after_t = pok ? esc_pkg::S_PA : (hok ? esc_pkg::S_HA : esc_pkg::S_FIN);
  assign after_p = hok ? esc_pkg::S_HA : esc_pkg::S_FIN;

  esc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  esc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (mul_p),
    .b     (rd),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp  <= 48'd0;
      cal_plo   <= 64'd0;
      cal_phi   <= 64'd0;
      cal_plast <= 16'd0;
      cal_hum   <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        esc_pkg::REG_CAL_TEMP:   cal_temp  <= cfg_data[47:0];
        esc_pkg::REG_PRESS_LOW:  cal_plo   <= cfg_data;
        esc_pkg::REG_PRESS_HIGH: cal_phi   <= cfg_data;
        esc_pkg::REG_PRESS_LAST: cal_plast <= cfg_data[15:0];
        esc_pkg::REG_CAL_HUM:    cal_hum   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esc_pkg::S_IDLE;
      ret   <= esc_pkg::S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    mul_a      = ra;
    mul_b      = rb;
    case (state)
      esc_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.raw_temp != esc_pkg::SKIP24) begin
            state_next = esc_pkg::S_TA;
          end else if (in_data.raw_press != esc_pkg::SKIP24) begin
            state_next = esc_pkg::S_PA;
          end else if (in_data.raw_hum != esc_pkg::SKIP16) begin
            state_next = esc_pkg::S_HA;
          end else begin
            state_next = esc_pkg::S_FIN;
          end
        end
      end
      esc_pkg::S_WAIT: begin
        if (mul_done || div_done) begin
          state_next = ret;
        end
      end
      esc_pkg::S_TA: state_next = esc_pkg::S_TB;
      esc_pkg::S_TB: begin
        mul_start = 1'b1; mul_a = ra; mul_b = t2;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_TC;
      end
      esc_pkg::S_TC: begin
        mul_start = 1'b1; mul_a = rb; mul_b = rb;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_TD;
      end
      esc_pkg::S_TD: begin
        mul_start = 1'b1; mul_a = 64'($signed(mul_p) >>> 12); mul_b = t3;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_TE;
      end
      esc_pkg::S_TE: state_next = esc_pkg::S_TF;
      esc_pkg::S_TF: state_next = after_t;
      esc_pkg::S_PA: state_next = esc_pkg::S_PB;
      esc_pkg::S_PB: begin
        mul_start = 1'b1; mul_a = ra; mul_b = ra;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_PC;
      end
      esc_pkg::S_PC: begin
        mul_start = 1'b1; mul_a = mul_p; mul_b = p6;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_PD;
      end
      esc_pkg::S_PD: begin
        mul_start = 1'b1; mul_a = ra; mul_b = p5;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_PE;
      end
      esc_pkg::S_PE: begin
        mul_start = 1'b1; mul_a = rb; mul_b = p3;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_PF;
      end
      esc_pkg::S_PF: begin
        mul_start = 1'b1; mul_a = ra; mul_b = p2;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_PG;
      end
      esc_pkg::S_PG: state_next = esc_pkg::S_PH;
      esc_pkg::S_PH: begin
        mul_start = 1'b1; mul_a = rd; mul_b = p1;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_PI;
      end
      esc_pkg::S_PI: state_next = esc_pkg::S_PJ;
      esc_pkg::S_PJ: begin
        state_next = (rd == 64'd0) ? after_p : esc_pkg::S_PK;
      end
      esc_pkg::S_PK: begin
        mul_start = 1'b1; mul_a = re; mul_b = 64'd3125;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_PL;
      end
      esc_pkg::S_PL: begin
        div_start = 1'b1;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_PM;
      end
      esc_pkg::S_PM: begin
        mul_start = 1'b1; mul_a = 64'($signed(div_q) >>> 13); mul_b = p9;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_PN;
      end
      esc_pkg::S_PN: begin
        mul_start = 1'b1; mul_a = mul_p; mul_b = rb;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_PO;
      end
      esc_pkg::S_PO: begin
        mul_start = 1'b1; mul_a = re; mul_b = p8;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_PP;
      end
      esc_pkg::S_PP: state_next = esc_pkg::S_PQ;
      esc_pkg::S_PQ: state_next = after_p;
      esc_pkg::S_HA: state_next = esc_pkg::S_HB;
      esc_pkg::S_HB: begin
        mul_start = 1'b1; mul_a = ra; mul_b = esc_pkg::sx32(h5);
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_HC;
      end
      esc_pkg::S_HC: begin
        mul_start = 1'b1; mul_a = ra; mul_b = esc_pkg::sx32(h6);
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_HD;
      end
      esc_pkg::S_HD: begin
        mul_start = 1'b1; mul_a = ra; mul_b = esc_pkg::sx32(h3);
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_HE;
      end
      esc_pkg::S_HE: state_next = esc_pkg::S_HF;
      esc_pkg::S_HF: begin
        mul_start = 1'b1; mul_a = rc; mul_b = rd;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_HG;
      end
      esc_pkg::S_HG: state_next = esc_pkg::S_HH;
      esc_pkg::S_HH: begin
        mul_start = 1'b1; mul_a = rc; mul_b = esc_pkg::sx32(h2);
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_HI;
      end
      esc_pkg::S_HI: state_next = esc_pkg::S_HJ;
      esc_pkg::S_HJ: begin
        mul_start = 1'b1; mul_a = rb; mul_b = rc;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_HK;
      end
      esc_pkg::S_HK: state_next = esc_pkg::S_HL;
      esc_pkg::S_HL: begin
        mul_start = 1'b1; mul_a = rc; mul_b = rc;
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_HM;
      end
      esc_pkg::S_HM: begin
        mul_start = 1'b1;
        mul_a = esc_pkg::sx32(32'($signed(p32) >>> 7));
        mul_b = esc_pkg::sx32(h1);
        state_next = esc_pkg::S_WAIT; ret_next = esc_pkg::S_HN;
      end
      esc_pkg::S_HN: state_next = esc_pkg::S_FIN;
      esc_pkg::S_FIN: begin
        if (out_free) begin
          state_next = esc_pkg::S_IDLE;
        end
      end
      default: state_next = esc_pkg::S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fine_temp <= 32'd0;
    end else begin
      case (state)
        esc_pkg::S_IDLE: begin
          raw_t   <= in_data.raw_temp;
          raw_p   <= in_data.raw_press;
          raw_h   <= in_data.raw_hum;
          tok     <= (in_data.raw_temp != esc_pkg::SKIP24);
          pok     <= (in_data.raw_press != esc_pkg::SKIP24);
          hok     <= (in_data.raw_hum != esc_pkg::SKIP16);
          temp_r  <= 32'd0;
          press_r <= 32'd0;
          hum_r   <= 17'd0;
        end
        esc_pkg::S_TA: begin
          ra <= {47'd0, adc_t[19:3]} - {t1[62:0], 1'b0};
          rb <= {48'd0, adc_t[19:4]} - t1;
        end
        esc_pkg::S_TC: ra <= 64'($signed(mul_p) >>> 11);
        esc_pkg::S_TE: fine_temp <= ra[31:0] + mul_p[45:14];
        esc_pkg::S_TF: temp_r <= 32'($signed({ts[61:0], 2'b00} + ts + 64'd128) >>> 8);
        esc_pkg::S_PA: ra <= ts - 64'd128000;
        esc_pkg::S_PC: rb <= mul_p;
        esc_pkg::S_PD: rc <= mul_p;
        esc_pkg::S_PE: rc <= rc + {mul_p[46:0], 17'd0} + {p4[28:0], 35'd0};
        esc_pkg::S_PF: rd <= 64'($signed(mul_p) >>> 8);
        esc_pkg::S_PG: rd <= rd + {mul_p[51:0], 12'd0} + (64'd1 << 47);
        esc_pkg::S_PI: rd <= 64'($signed(mul_p) >>> 33);
        esc_pkg::S_PJ: begin
          if (rd == 64'd0) begin
            press_r <= 32'd0;
          end else begin
            re <= ((64'd1048576 - {44'd0, adc_p}) << 31) - rc;
          end
        end
        esc_pkg::S_PM: begin
          re <= div_q;
          rb <= 64'($signed(div_q) >>> 13);
        end
        esc_pkg::S_PO: ra <= 64'($signed(mul_p) >>> 25);
        esc_pkg::S_PP: rc <= re + ra + 64'($signed(mul_p) >>> 19);
        esc_pkg::S_PQ: press_r <= 32'(64'($signed(rc) >>> 8) + {p7[59:0], 4'd0});
        esc_pkg::S_HA: ra <= esc_pkg::sx32(fine_temp - 32'd76800);
        esc_pkg::S_HC: rb <= esc_pkg::sx32(hx);
        esc_pkg::S_HD: rc <= esc_pkg::sx32(32'($signed(p32) >>> 10));
        esc_pkg::S_HE: rd <= esc_pkg::sx32(32'($signed(p32) >>> 11) + 32'd32768);
        esc_pkg::S_HG: rc <= esc_pkg::sx32(32'($signed(p32) >>> 10) + 32'd2097152);
        esc_pkg::S_HI: rc <= esc_pkg::sx32(32'($signed(p32 + 32'd8192) >>> 14));
        esc_pkg::S_HK: begin
          rd <= esc_pkg::sx32(p32);
          rc <= esc_pkg::sx32(32'($signed(p32) >>> 15));
        end
        esc_pkg::S_HN: begin
          if (hv[31]) begin
            hum_r <= 17'd0;
          end else if (hv > esc_pkg::HUM_MAX) begin
            hum_r <= esc_pkg::HUM_MAX[28:12];
          end else begin
            hum_r <= hv[28:12];
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == esc_pkg::S_FIN && out_free) begin
      out_valid            <= 1'b1;
      out_data.temp_centi  <= temp_r;
      out_data.temp_ok     <= tok;
      out_data.press_q24_8 <= press_r;
      out_data.press_ok    <= pok;
      out_data.hum_q22_10  <= hum_r;
      out_data.hum_ok      <= hok;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/esc_mul.sv -----
// bit-serial shift-add multiplier, low 64 bits of a signed product
`default_nettype none
module esc_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      p
);

  logic        busy;
  logic        neg;
  logic [63:0] ma;
  logic [63:0] mb;
  logic [63:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma   <= a;
        mb   <= b[63] ? (64'd0 - b) : b;
        neg  <= b[63];
        acc  <= 64'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (mb == 64'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          p    <= neg ? (64'd0 - acc) : acc;
        end else begin
          if (mb[0]) begin
            acc <= acc + ma;
          end
          ma <= {ma[62:0], 1'b0};
          mb <= {1'b0, mb[63:1]};
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/esc_div.sv -----
// bit-serial restoring divider, signed 64-bit quotient truncated toward zero
`default_nettype none
module esc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      q
);

  logic        busy;
  logic        fix;
  logic        neg;
  logic [6:0]  cnt;
  logic [63:0] ub;
  logic [63:0] quo;
  logic [64:0] rem;
  logic [64:0] rem_sh;

  assign rem_sh = {rem[63:0], quo[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= a[63] ? (64'd0 - a) : a;
        ub   <= b[63] ? (64'd0 - b) : b;
        neg  <= a[63] ^ b[63];
        rem  <= 65'd0;
        cnt  <= 7'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem_sh >= {1'b0, ub}) begin
          rem <= rem_sh - {1'b0, ub};
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
        q    <= neg ? (64'd0 - quo) : quo;
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/env_sensor_compensation_unit_test.sv -----
// self-checking testbench for the sensor compensation block
`timescale 1ns / 100ps
`default_nettype none
module env_sensor_compensation_unit_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  esc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  esc_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [esc_pkg::CfgIdxW-1:0] cfg_index = esc_pkg::REG_CAL_TEMP;
  logic [63:0] cfg_data = '0;

  always #5 clk = ~clk;

  env_sensor_compensation_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of calibration and fine temperature
  logic [47:0] cal_t;
  logic [63:0] cal_pl, cal_ph, cal_h;
  logic [15:0] cal_p9;
  logic [31:0] fine_t;
  esc_pkg::out_item_t readings_due[$];
  int errors = 0;
  int gap_max = 3;
  bit hold_off = 1'b0;
  bit quiet = 1'b0;

  function automatic logic [31:0] comp_temp(input logic [23:0] raw);
    logic signed [63:0] adc, t1, t2, t3, a, b, v1, v2, ft;
    adc = raw >> 4;
    t1 = {48'd0, cal_t[15:0]};
    t2 = $signed(cal_t[31:16]);
    t3 = $signed(cal_t[47:32]);
    a = (adc >>> 3) - (t1 <<< 1);
    b = (adc >>> 4) - t1;
    v1 = (a * t2) >>> 11;
    v2 = (((b * b) >>> 12) * t3) >>> 14;
    fine_t = v1[31:0] + v2[31:0];
    ft = $signed(fine_t);
    ft = (ft * 5 + 128) >>> 8;
    return ft[31:0];
  endfunction

  function automatic logic [31:0] comp_press(input logic [23:0] raw);
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, q, num;
    logic [63:0] ua, ub, uq;
    p1 = {48'd0, cal_pl[15:0]};
    p2 = $signed(cal_pl[31:16]); p3 = $signed(cal_pl[47:32]);
    p4 = $signed(cal_pl[63:48]);
    p5 = $signed(cal_ph[15:0]); p6 = $signed(cal_ph[31:16]);
    p7 = $signed(cal_ph[47:32]); p8 = $signed(cal_ph[63:48]);
    p9 = $signed(cal_p9);
    v1 = $signed(fine_t);
    v1 = v1 - 128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) return 32'd0;
    p = 64'sd1048576 - (raw >> 4);
    num = ((p <<< 31) - v2) * 3125;
    ua = num[63] ? -num : num;
    ub = v1[63] ? -v1 : v1;
    uq = ua / ub;
    p = (num[63] != v1[63]) ? -uq : uq;
    q = p >>> 13;
    v1 = (p9 * q * q) >>> 25;
    v2 = (p8 * p) >>> 19;
    p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
    return p[31:0];
  endfunction

  function automatic logic [16:0] comp_hum(input logic [15:0] raw);
    logic signed [31:0] h1, h2, h3, h4, h5, h6, v, x, y, s, rw;
    h1 = {24'd0, cal_h[7:0]};
    h2 = $signed(cal_h[23:8]);
    h3 = {24'd0, cal_h[31:24]};
    h4 = $signed(cal_h[43:32]);
    h5 = $signed(cal_h[55:44]);
    h6 = $signed(cal_h[63:56]);
    rw = {16'd0, raw};
    v = fine_t - 32'd76800;
    x = ((rw <<< 14) - (h4 <<< 20) - h5 * v + 16384) >>> 15;
    y = (((v * h6) >>> 10) * (((v * h3) >>> 11) + 32768)) >>> 10;
    y = ((y + 2097152) * h2 + 8192) >>> 14;
    v = x * y;
    s = v >>> 15;
    v = v - ((((s * s) >>> 7) * h1) >>> 4);
    if (v[31]) v = 0;
    else if (v > esc_pkg::HUM_MAX) v = esc_pkg::HUM_MAX;
    return v[28:12];
  endfunction

  function automatic esc_pkg::out_item_t compensate(input esc_pkg::in_item_t it);
    esc_pkg::out_item_t r;
    r = '0;
    r.temp_ok = it.raw_temp != esc_pkg::SKIP24;
    r.press_ok = it.raw_press != esc_pkg::SKIP24;
    r.hum_ok = it.raw_hum != esc_pkg::SKIP16;
    if (r.temp_ok) r.temp_centi = comp_temp(it.raw_temp);
    if (r.press_ok) r.press_q24_8 = comp_press(it.raw_press);
    if (r.hum_ok) r.hum_q22_10 = comp_hum(it.raw_hum);
    return r;
  endfunction

  task automatic write_cal(input logic [esc_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      esc_pkg::REG_CAL_TEMP: cal_t = val[47:0];
      esc_pkg::REG_PRESS_LOW: cal_pl = val;
      esc_pkg::REG_PRESS_HIGH: cal_ph = val;
      esc_pkg::REG_PRESS_LAST: cal_p9 = val[15:0];
      esc_pkg::REG_CAL_HUM: cal_h = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_reading(input esc_pkg::in_item_t it);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(0, gap_max);
    repeat (gap + 1) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    readings_due.push_back(compensate(it));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // typical sensor trimming with some randomisation
  task automatic load_typical;
    write_cal(esc_pkg::REG_CAL_TEMP, {16'sd50, 16'sd26435, 16'd27504} ^
      {16'd0, 16'($urandom_range(0, 255)), 16'($urandom_range(0, 255))});
    write_cal(esc_pkg::REG_PRESS_LOW, {16'sd2855, 16'sd3024, 16'(-16'sd10685), 16'd36477});
    write_cal(esc_pkg::REG_PRESS_HIGH, {16'(-16'sd12000), 16'sd15500, 16'(-16'sd7), 16'sd140});
    write_cal(esc_pkg::REG_PRESS_LAST, 64'd4285);
    write_cal(esc_pkg::REG_CAL_HUM, {8'd30, 12'd50, 12'd318, 8'd0, 16'sd365, 8'd75});
  endtask

  function automatic esc_pkg::in_item_t typical_reading;
    esc_pkg::in_item_t it;
    it.raw_temp = 24'h7e0000 + 24'($urandom_range(0, 24'h03ffff));
    it.raw_press = 24'h500000 + 24'($urandom_range(0, 24'h1fffff));
    it.raw_hum = 16'h6000 + 16'($urandom_range(0, 16'h1fff));
    if ($urandom_range(0, 15) == 0) it.raw_temp = esc_pkg::SKIP24;
    if ($urandom_range(0, 15) == 0) it.raw_press = esc_pkg::SKIP24;
    if ($urandom_range(0, 15) == 0) it.raw_hum = esc_pkg::SKIP16;
    return it;
  endfunction

  function automatic esc_pkg::in_item_t wild_reading;
    esc_pkg::in_item_t it;
    it = {$urandom, $urandom};
    return it;
  endfunction

  task automatic test_reset_values;
    send_reading('0);
    send_reading({24'hffffff, 24'hffffff, 16'hffff});
    send_reading({esc_pkg::SKIP24, esc_pkg::SKIP24, esc_pkg::SKIP16});
    drain();
  endtask

  task automatic test_directed;
    load_typical();
    send_reading({24'h7effa0, 24'h655a30, 16'h6ff0});
    send_reading({esc_pkg::SKIP24, 24'h655a30, 16'h6ff0});
    send_reading({24'h000000, 24'h000000, 16'h0000});
    send_reading({24'hffffff, 24'hffffff, 16'hffff});
    send_reading({24'h7ffff0, esc_pkg::SKIP24, 16'h7fff});
    send_reading({24'h800010, 24'h800010, esc_pkg::SKIP16});
    send_reading({esc_pkg::SKIP24, esc_pkg::SKIP24, 16'h8001});
    drain();
    // zero pressure divisor
    write_cal(esc_pkg::REG_PRESS_LOW, 64'd0);
    send_reading({24'h7effa0, 24'h655a30, 16'h6ff0});
    drain();
    // extreme coefficients
    write_cal(esc_pkg::REG_CAL_TEMP, 48'hffff_ffff_ffff);
    write_cal(esc_pkg::REG_PRESS_LOW, 64'hffff_ffff_ffff_ffff);
    write_cal(esc_pkg::REG_PRESS_HIGH, 64'hffff_ffff_ffff_ffff);
    write_cal(esc_pkg::REG_PRESS_LAST, 64'hffff);
    write_cal(esc_pkg::REG_CAL_HUM, 64'hffff_ffff_ffff_ffff);
    send_reading({24'h000000, 24'hffffff, 16'hffff});
    send_reading({24'hffffff, 24'h000000, 16'h0000});
    drain();
    write_cal(esc_pkg::REG_CAL_TEMP, 48'h8000_8000_0000);
    write_cal(esc_pkg::REG_PRESS_LOW, 64'h8000_8000_8000_ffff);
    write_cal(esc_pkg::REG_PRESS_HIGH, 64'h8000_8000_8000_8000);
    write_cal(esc_pkg::REG_PRESS_LAST, 64'h8000);
    write_cal(esc_pkg::REG_CAL_HUM, 64'h8080_0800_ff80_00ff);
    send_reading({24'hffffff, 24'h000000, 16'hffff});
    send_reading({24'h000000, 24'h7ffff0, 16'h0000});
    drain();
  endtask

  task automatic test_random(input int n);
    int burst;
    int k;
    k = 0;
    while (k < n) begin
      if (k % 100 == 0) begin
        drain();
        if ($urandom_range(0, 3) == 0) begin
          write_cal(esc_pkg::REG_CAL_TEMP, {$urandom, $urandom});
          write_cal(esc_pkg::REG_PRESS_LOW, {$urandom, $urandom});
          write_cal(esc_pkg::REG_PRESS_HIGH, {$urandom, $urandom});
          write_cal(esc_pkg::REG_PRESS_LAST, {$urandom, $urandom});
          write_cal(esc_pkg::REG_CAL_HUM, {$urandom, $urandom});
        end else begin
          load_typical();
        end
      end
      burst = $urandom_range(1, 12);
      quiet = burst > 8;
      repeat (burst) begin
        send_reading(($urandom_range(0, 4) == 0) ? wild_reading() : typical_reading());
        k++;
      end
      quiet = 1'b0;
      repeat ($urandom_range(0, 40)) @(negedge clk);
    end
    drain();
  endtask

  task automatic test_backpressure;
    load_typical();
    hold_off = 1'b1;
    quiet = 1'b1;
    fork
      begin
        repeat (5000) @(negedge clk);
        hold_off = 1'b0;
      end
      repeat (6) send_reading(typical_reading());
    join
    quiet = 1'b0;
    drain();
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (($time / 20000) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    esc_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = readings_due.pop_front();
        if (out_data.temp_centi !== want.temp_centi || out_data.temp_ok !== want.temp_ok) begin
          $display("%0t: temperature expected %0d/%b actual %0d/%b", $time,
            want.temp_centi, want.temp_ok, out_data.temp_centi, out_data.temp_ok);
          errors++;
        end
        if (out_data.press_q24_8 !== want.press_q24_8 || out_data.press_ok !== want.press_ok) begin
          $display("%0t: pressure expected %h/%b actual %h/%b", $time,
            want.press_q24_8, want.press_ok, out_data.press_q24_8, out_data.press_ok);
          errors++;
        end
        if (out_data.hum_q22_10 !== want.hum_q22_10 || out_data.hum_ok !== want.hum_ok) begin
          $display("%0t: humidity expected %0d/%b actual %0d/%b", $time,
            want.hum_q22_10, want.hum_ok, out_data.hum_q22_10, out_data.hum_ok);
          errors++;
        end
      end
    end
  end

  initial begin
    cal_t = '0; cal_pl = '0; cal_ph = '0; cal_p9 = '0; cal_h = '0; fine_t = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed();
    test_backpressure();
    test_random(400);
    if (errors == 0 && readings_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
